FILE: sv/mnrt_pkg.sv
// ----------------------------------------------------------------------------
// mnrt_pkg: shared types and constants for the mesh neighbor/route table
// Commands, status codes, register indexes and default settings.
// ----------------------------------------------------------------------------
package mnrt_pkg;

	localparam int ADDR_W      = 48;
	localparam int NBR_DEPTH   = 32;
	localparam int ROUTE_DEPTH = 64;

	localparam logic [7:0] SUCC_WEIGHT_RST = 8'd205;
	localparam logic [7:0] RAND_WEIGHT_RST = 8'd51;

	typedef enum logic [1:0] {
		CMD_HELLO  = 2'd0,
		CMD_ADVERT = 2'd1,
		CMD_LOOKUP = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		NS_NA      = 3'd0,
		NS_ADDED   = 3'd1,
		NS_UPDATED = 3'd2,
		NS_FULL    = 3'd3,
		NS_UNKNOWN = 3'd4
	} nbr_status_t;

	typedef enum logic [2:0] {
		RS_ADDED   = 3'd0,
		RS_UPDATED = 3'd1,
		RS_IGNORED = 3'd2,
		RS_FULL    = 3'd3,
		RS_HIT     = 3'd4,
		RS_MISS    = 3'd5,
		RS_NONE    = 3'd6
	} rt_status_t;

	localparam logic [1:0] REG_LOCAL_ADDR = 2'd0;
	localparam logic [1:0] REG_SUCC_WT    = 2'd1;
	localparam logic [1:0] REG_RAND_WT    = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NSCAN,
		ST_NWAIT,
		ST_NRD,
		ST_NCALC,
		ST_NWR,
		ST_DIV,
		ST_RSCAN,
		ST_RWAIT,
		ST_RWR,
		ST_OUT
	} state_t;

	// gap-based packet loss
	function automatic logic [7:0] seq_loss(input logic [7:0] gap);
		logic [7:0] l;
		if (gap <= 8'd1)
			l = 8'd0;
		else if (gap < 8'd16)
			l = {gap[3:0], 4'b0000};
		else
			l = 8'hFF;
		return l;
	endfunction

endpackage

FILE: sv/mnrt_if.sv
// ----------------------------------------------------------------------------
// mnrt_if: valid/ready channel interfaces
// Request, result and configuration channels.
// ----------------------------------------------------------------------------
interface mnrt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [47:0] source_address;
	logic [7:0]  sequence_req;
	logic [7:0]  randomness;
	logic [47:0] target_address;
	logic [7:0]  advertised_distance;
	logic [7:0]  advertised_metric;
	modport source(output valid, cmd, source_address, sequence_req, randomness,
		target_address, advertised_distance, advertised_metric, input ready);
	modport sink(input valid, cmd, source_address, sequence_req, randomness,
		target_address, advertised_distance, advertised_metric, output ready);
endinterface

interface mnrt_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  neighbor_status;
	logic [4:0]  neighbor_slot;
	logic [7:0]  neighbor_quality;
	logic [2:0]  route_status;
	logic [5:0]  route_slot;
	logic [47:0] next_hop;
	logic [7:0]  route_hops;
	logic [7:0]  route_quality;
	modport source(output valid, neighbor_status, neighbor_slot, neighbor_quality,
		route_status, route_slot, next_hop, route_hops, route_quality, input ready);
	modport sink(input valid, neighbor_status, neighbor_slot, neighbor_quality,
		route_status, route_slot, next_hop, route_hops, route_quality, output ready);
endinterface

interface mnrt_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [47:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

FILE: sv/mesh_neighbor_route_table.sv
// ----------------------------------------------------------------------------
// mesh_neighbor_route_table: neighbor table and distance-vector route table
// Hellos, advertised routes and lookups against two synchronous memories.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  req     | in  | cmd, addresses, sequence, randomness, advertised route
//  rsp     | out | neighbor status/slot/quality, route status/slot/hop/hops/quality
//  cfg     | in  | register index, write data
//
// One request at a time. Hellos and advertised routes scan the N neighbor entries
// in use and then the R route entries in use, one entry per cycle; an advertised
// route runs the bit-serial divider between the two scans. A lookup scans only
// the route entries.
// After reset both tables are empty; no clearing pass. The result register
// holds while rsp.ready is low; the next request waits until it is taken.
module mesh_neighbor_route_table #(
	parameter int NBR_DEPTH   = mnrt_pkg::NBR_DEPTH,
	parameter int ROUTE_DEPTH = mnrt_pkg::ROUTE_DEPTH
) (
	input logic   clk,
	input logic   arst_n,
	mnrt_req_if.sink   req,
	mnrt_rsp_if.source rsp,
	mnrt_cfg_if.sink   cfg
);
	import mnrt_pkg::*;

	localparam int NAW = $clog2(NBR_DEPTH);
	localparam int RAW = $clog2(ROUTE_DEPTH);

	// config
	logic [47:0] local_addr_q;
	logic [7:0]  succ_wt_q, rand_wt_q;

	// request copy
	cmd_t        cmd_q;
	logic [47:0] src_q, tgt_q;
	logic [7:0]  seq_q, rnd_q, adist_q, amet_q;

	state_t      state_q, state_d;
	logic [NAW:0] nbr_cnt_q;
	logic [RAW:0] rt_cnt_q;
	logic [NAW:0] nidx_q;
	logic [RAW:0] ridx_q;
	logic         nfound_q;
	logic [NAW-1:0] nslot_q;
	logic         rfound_q;
	logic [RAW-1:0] rslot_q;
	logic         rstop_q;   // advert/hello: offer beats the first matching destination

	logic [7:0]  prior_q, succ_q, nq_q, hops_q, store_q, cmp_q;
	logic [47:0] dest_q;
	logic [15:0] prod_a_q, prod_b_q;

	// result
	logic        out_valid_q;
	nbr_status_t ns_q;
	logic [NAW-1:0] nsl_q;
	logic [7:0]  nqo_q;
	rt_status_t  rs_q;
	logic [RAW-1:0] rsl_q;
	logic [47:0] nh_q;
	logic [7:0]  rh_q, rq_q;

	// memories
	logic          nwe;
	logic [71:0]   nwdata, nrdata;
	logic [NAW-1:0] nraddr;
	logic          rwe;
	logic [111:0]  rwdata, rrdata;
	logic [RAW-1:0] rraddr;
	logic          scan_n_s1, scan_r_s1;   // read issued last cycle is a scan read
	logic [NAW-1:0] nrd_idx_s1;
	logic [RAW-1:0] rrd_idx_s1;

	logic        div_start, div_done;
	logic [15:0] div_quo, div_dvd;

	logic        nbr_full, rt_full;
	assign nbr_full = (nbr_cnt_q == (NAW+1)'(NBR_DEPTH));
	assign rt_full  = (rt_cnt_q == (RAW+1)'(ROUTE_DEPTH));

	assign nraddr = (state_q == ST_NSCAN) ? nidx_q[NAW-1:0] : nslot_q;
	assign rraddr = ridx_q[RAW-1:0];

	mnrt_nbr_mem #(.DEPTH(NBR_DEPTH), .AW(NAW)) u_nbr (
		.clk(clk), .we(nwe), .waddr(nslot_q), .wdata(nwdata),
		.raddr(nraddr), .rdata(nrdata));

	mnrt_rt_mem #(.DEPTH(ROUTE_DEPTH), .AW(RAW)) u_rt (
		.clk(clk), .we(rwe), .waddr(rslot_q), .wdata(rwdata),
		.raddr(rraddr), .rdata(rrdata));

	assign div_dvd = {8'd0, nq_q} + amet_q * (hops_q - 8'd1);
	mnrt_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dvd),
		.divisor(hops_q), .done(div_done), .quotient(div_quo));

	assign req.ready = (state_q == ST_IDLE) && !out_valid_q;
	assign cfg.ready = 1'b1;

	logic [47:0] nr_addr;
	logic [7:0]  nr_seq, nr_succ, nr_q;
	assign {nr_addr, nr_seq, nr_succ, nr_q} = nrdata;
	logic [47:0] rr_dst, rr_nh;
	logic [7:0]  rr_dist, rr_q;
	assign {rr_dst, rr_nh, rr_dist, rr_q} = rrdata;

	logic nscan_end, rscan_end;
	assign nscan_end = (nidx_q >= nbr_cnt_q);
	assign rscan_end = (ridx_q >= rt_cnt_q);

	logic [7:0] loss_q;
	logic [7:0] gap, loss, succ_new;
	assign gap      = seq_q - nr_seq;
	assign loss     = seq_loss(gap);
	assign succ_new = (prior_q > loss_q) ? prior_q - loss_q : 8'd0;

	logic [16:0] msum;
	logic [8:0]  metric;
	logic [7:0]  met_sat;
	assign msum    = {1'b0, prod_a_q} + {1'b0, prod_b_q};
	assign metric  = msum[16:8];
	assign met_sat = metric[8] ? 8'hFF : metric[7:0];

	logic rmatch, rwin;
	assign rmatch = (rr_dst == dest_q);
	assign rwin   = (rr_nh == src_q) || (hops_q < rr_dist) ||
		((hops_q == rr_dist) && (cmp_q > rr_q));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:
				if (req.valid && req.ready) begin
					priority case (cmd_t'(req.cmd))
						CMD_HELLO, CMD_ADVERT: state_d = ST_NSCAN;
						CMD_LOOKUP:            state_d = ST_RSCAN;
						default:               state_d = ST_OUT;
					endcase
				end
			ST_NSCAN: if (nscan_end) state_d = ST_NWAIT;
			ST_NWAIT: state_d = ST_NRD;
			ST_NRD: begin
				if (!nfound_q && (cmd_q == CMD_ADVERT || nbr_full))
					state_d = ST_OUT;
				else
					state_d = ST_NCALC;
			end
			ST_NCALC: state_d = (cmd_q == CMD_HELLO) ? ST_NWR : ST_DIV;
			ST_NWR:   state_d = (src_q == local_addr_q) ? ST_OUT : ST_RSCAN;
			ST_DIV:   if (div_done) state_d = (tgt_q == local_addr_q) ? ST_OUT : ST_RSCAN;
			ST_RSCAN: if (rscan_end || rstop_q) state_d = ST_RWAIT;
			ST_RWAIT: state_d = (cmd_q == CMD_LOOKUP) ? ST_OUT : ST_RWR;
			ST_RWR:   state_d = ST_OUT;
			ST_OUT:   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs to memories and divider
	always_comb begin
		nwe       = (state_q == ST_NWR);
		nwdata    = {src_q, seq_q, succ_q, met_sat};
		rwe       = (state_q == ST_RWR) && !(rfound_q && !rstop_q) &&
			!(!rfound_q && rt_full);
		rwdata    = {dest_q, src_q, hops_q, store_q};
		div_start = (state_q == ST_NCALC) && (cmd_q == CMD_ADVERT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			nbr_cnt_q    <= '0;
			rt_cnt_q     <= '0;
			out_valid_q  <= 1'b0;
			local_addr_q <= '0;
			succ_wt_q    <= SUCC_WEIGHT_RST;
			rand_wt_q    <= RAND_WEIGHT_RST;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				unique case (cfg.index)
					REG_LOCAL_ADDR: local_addr_q <= cfg.data;
					REG_SUCC_WT:    succ_wt_q    <= cfg.data[7:0];
					REG_RAND_WT:    rand_wt_q    <= cfg.data[7:0];
					default:        ;
				endcase
			end
			if (state_q == ST_NWR && !nfound_q)
				nbr_cnt_q <= nbr_cnt_q + 1'b1;
			if (rwe && !rfound_q)
				rt_cnt_q <= rt_cnt_q + 1'b1;
			if (state_q == ST_OUT)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		scan_n_s1  <= (state_q == ST_NSCAN) && !nscan_end;
		nrd_idx_s1 <= nidx_q[NAW-1:0];
		scan_r_s1  <= (state_q == ST_RSCAN) && !rscan_end && !rstop_q;
		rrd_idx_s1 <= ridx_q[RAW-1:0];
		unique case (state_q)
			ST_IDLE: if (req.valid && req.ready) begin
				cmd_q    <= cmd_t'(req.cmd);
				src_q    <= req.source_address;
				tgt_q    <= req.target_address;
				seq_q    <= req.sequence_req;
				rnd_q    <= req.randomness;
				adist_q  <= req.advertised_distance;
				amet_q   <= req.advertised_metric;
				nidx_q   <= '0;
				ridx_q   <= '0;
				nfound_q <= 1'b0;
				rfound_q <= 1'b0;
				rstop_q  <= 1'b0;
				ns_q  <= NS_NA; nsl_q <= '0; nqo_q <= '0;
				rs_q  <= RS_NONE; rsl_q <= '0; nh_q <= '0; rh_q <= '0; rq_q <= '0;
				dest_q <= (cmd_t'(req.cmd) == CMD_HELLO) ? req.source_address
					: req.target_address;
			end
			ST_NSCAN: if (!nscan_end) nidx_q <= nidx_q + 1'b1;
			ST_NRD: begin
				// nrdata holds the found entry (or junk when new)
				if (nfound_q) begin
					prior_q <= (gap == 8'd0) ? 8'hFF : nr_succ;
					loss_q  <= (gap == 8'd0) ? 8'd0 : loss;
					nq_q    <= nr_q;
				end else begin
					prior_q <= 8'hFF;
					loss_q  <= 8'd0;
					nslot_q <= nbr_cnt_q[NAW-1:0];
				end
				hops_q <= (adist_q == 8'hFF) ? 8'hFF : adist_q + 8'd1;
				if (!nfound_q) begin
					if (cmd_q == CMD_ADVERT) ns_q <= NS_UNKNOWN;
					else if (nbr_full) ns_q <= NS_FULL;
				end
			end
			ST_NCALC: begin
				succ_q <= succ_new;
				if (cmd_q == CMD_HELLO) begin
					prod_a_q <= prior_q * succ_wt_q;
					prod_b_q <= rnd_q * rand_wt_q;
					hops_q   <= 8'd1;
				end else begin
					cmp_q    <= amet_q;
					ns_q     <= NS_NA;
					nsl_q    <= nslot_q;
					nqo_q    <= nq_q;
					if (tgt_q == local_addr_q) rs_q <= RS_IGNORED;
				end
			end
			ST_NWR: begin
				store_q <= met_sat;
				cmp_q   <= met_sat;
				ns_q    <= nfound_q ? NS_UPDATED : NS_ADDED;
				nsl_q   <= nslot_q;
				nqo_q   <= met_sat;
				if (src_q == local_addr_q) rs_q <= RS_IGNORED;
			end
			ST_DIV: if (div_done) store_q <= div_quo[7:0];
			ST_RSCAN: if (!rscan_end && !rstop_q) ridx_q <= ridx_q + 1'b1;
			ST_RWAIT: if (cmd_q == CMD_LOOKUP) begin
				if (rfound_q) begin
					rs_q <= RS_HIT;
				end else
					rs_q <= RS_MISS;
			end
			ST_RWR: begin
				if (rfound_q && !rstop_q) begin
					rs_q <= RS_IGNORED;
				end else if (!rfound_q && rt_full) begin
					rs_q <= RS_FULL;
				end else begin
					rs_q  <= rfound_q ? RS_UPDATED : RS_ADDED;
					rsl_q <= rfound_q ? rslot_q : rt_cnt_q[RAW-1:0];
					nh_q  <= src_q;
					rh_q  <= hops_q;
					rq_q  <= store_q;
				end
			end
			default: ;
		endcase
		// scan result capture, in the cycle after each read
		if (scan_n_s1 && nr_addr == src_q) begin
			nfound_q <= 1'b1;
			nslot_q  <= nrd_idx_s1;
		end
		if (scan_r_s1 && rmatch) begin
			if (cmd_q == CMD_LOOKUP) begin
				rfound_q <= 1'b1;
				rsl_q    <= rrd_idx_s1;
				nh_q     <= rr_nh;
				rh_q     <= rr_dist;
				rq_q     <= rr_q;
			end else if (!rfound_q) begin
				rfound_q <= 1'b1;
				rstop_q  <= rwin;
				rslot_q  <= rrd_idx_s1;
			end
		end
		// append slot ready before the write cycle
		if (state_q == ST_RWAIT && !rfound_q)
			rslot_q <= rt_cnt_q[RAW-1:0];
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.neighbor_status  = ns_q;
	assign rsp.neighbor_slot    = 5'(nsl_q);
	assign rsp.neighbor_quality = nqo_q;
	assign rsp.route_status     = rs_q;
	assign rsp.route_slot       = 6'(rsl_q);
	assign rsp.next_hop         = nh_q;
	assign rsp.route_hops       = rh_q;
	assign rsp.route_quality    = rq_q;

`ifndef SYNTHESIS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> state_q == ST_IDLE) else $error("ready outside idle");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid) else $error("result dropped");
	a_nbr_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		nbr_cnt_q <= (NAW+1)'(NBR_DEPTH)) else $error("neighbor count overflow");
	a_rt_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rt_cnt_q <= (RAW+1)'(ROUTE_DEPTH)) else $error("route count overflow");
`endif
endmodule

FILE: sv/mnrt_divider.sv
// ----------------------------------------------------------------------------
// mnrt_divider: restoring divider, one quotient bit per cycle
// Divides a 16-bit dividend by an 8-bit nonzero divisor.
// ----------------------------------------------------------------------------
module mnrt_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] dividend,
	input  logic [7:0]  divisor,
	output logic        done,
	output logic [15:0] quotient
);
	logic [15:0] quo_q;
	logic [8:0]  rem_q;
	logic [7:0]  dvs_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [9:0]  trial;

	assign trial = {rem_q, quo_q[15]} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd16;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[9]) begin
				rem_q <= trial[8:0];
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q <= {rem_q[7:0], quo_q[15]};
				quo_q <= {quo_q[14:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
endmodule

FILE: sv/mnrt_nbr_mem.sv
// ----------------------------------------------------------------------------
// mnrt_nbr_mem: neighbor table storage
// One write port, one registered read port.
// ----------------------------------------------------------------------------
module mnrt_nbr_mem #(
	parameter int DEPTH = mnrt_pkg::NBR_DEPTH,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [71:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [71:0]   rdata
);
	logic [71:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

FILE: sv/mnrt_rt_mem.sv
// ----------------------------------------------------------------------------
// mnrt_rt_mem: route table storage
// One write port, one registered read port.
// ----------------------------------------------------------------------------
module mnrt_rt_mem #(
	parameter int DEPTH = mnrt_pkg::ROUTE_DEPTH,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [111:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [111:0]  rdata
);
	logic [111:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

FILE: bench/mesh_neighbor_route_table_tb.sv
// ----------------------------------------------------------------------------
// mesh_neighbor_route_table_tb: self-checking bench for the neighbor/route table
// Drives hellos, advertised routes, lookups and CMD_NONE requests; a local
// model of both tables predicts every result, compared field by field.
// ----------------------------------------------------------------------------
module mesh_neighbor_route_table_tb;
	import mnrt_pkg::*;

	typedef struct packed {
		logic [2:0]  nstat;
		logic [4:0]  nslot;
		logic [7:0]  nqual;
		logic [2:0]  rstat;
		logic [5:0]  rslot;
		logic [47:0] hop;
		logic [7:0]  hops;
		logic [7:0]  rqual;
	} table_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #5 clk = ~clk;

	mnrt_req_if req ();
	mnrt_rsp_if rsp ();
	mnrt_cfg_if cfg ();

	mesh_neighbor_route_table u_dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.cfg(cfg));

	// model state
	logic [47:0] m_local;
	logic [7:0]  m_swt, m_rwt;
	logic [47:0] m_naddr [NBR_DEPTH];
	logic [7:0]  m_nseq [NBR_DEPTH];
	logic [7:0]  m_nsucc [NBR_DEPTH];
	logic [7:0]  m_nqual [NBR_DEPTH];
	int          m_ncount;
	logic [47:0] m_rdest [ROUTE_DEPTH];
	logic [47:0] m_rhop [ROUTE_DEPTH];
	logic [7:0]  m_rdist [ROUTE_DEPTH];
	logic [7:0]  m_rqual [ROUTE_DEPTH];
	int          m_rcount;

	table_result_t pending_results [$];
	int mismatches = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_cycles = 0;
	longint cycles = 0;
	logic [47:0] addr_pool [16];

	task automatic report(input string what, input logic [47:0] got, input logic [47:0] want);
		$display("MISMATCH %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
		mismatches++;
	endtask

	function automatic void offer_route(input logic [47:0] dest, input logic [47:0] hop,
			input logic [7:0] hop_dist, input logic [7:0] cmp_q, input logic [7:0] store_q,
			inout table_result_t r);
		int slot;
		slot = m_rcount;
		if (dest == m_local) begin
			r.rstat = RS_IGNORED;
			return;
		end
		for (int i = 0; i < m_rcount; i++) begin
			if (m_rdest[i] == dest) begin
				if (m_rhop[i] == hop || hop_dist < m_rdist[i] ||
						(hop_dist == m_rdist[i] && cmp_q > m_rqual[i])) begin
					slot = i;
					break;
				end
				r.rstat = RS_IGNORED;
				return;
			end
		end
		if (slot >= ROUTE_DEPTH) begin
			r.rstat = RS_FULL;
			return;
		end
		m_rdest[slot] = dest;
		m_rhop[slot] = hop;
		m_rdist[slot] = hop_dist;
		m_rqual[slot] = store_q;
		r.rstat = (slot == m_rcount) ? RS_ADDED : RS_UPDATED;
		r.rslot = 6'(slot);
		r.hop = hop;
		r.hops = hop_dist;
		r.rqual = store_q;
		if (slot == m_rcount)
			m_rcount++;
	endfunction

	function automatic int find_neighbor(input logic [47:0] a);
		int f;
		f = -1;
		for (int i = 0; i < m_ncount; i++)
			if (m_naddr[i] == a)
				f = i;
		return f;
	endfunction

	function automatic table_result_t predict_table(input cmd_t c, input logic [47:0] src,
			input logic [7:0] seq, input logic [7:0] rnd, input logic [47:0] tgt,
			input logic [7:0] adist, input logic [7:0] amet);
		table_result_t r;
		int n, slot, hit;
		int unsigned prior, loss, succ, met, gap, hops;
		r = '0;
		r.rstat = RS_NONE;
		case (c)
			CMD_HELLO: begin
				n = find_neighbor(src);
				if (n < 0) begin
					if (m_ncount >= NBR_DEPTH) begin
						r.nstat = NS_FULL;
						return r;
					end
					slot = m_ncount;
					prior = 255;
					loss = 0;
				end else begin
					slot = n;
					gap = (seq - m_nseq[slot]) & 8'hFF;
					prior = m_nsucc[slot];
					if (gap == 0) begin
						prior = 255;
						loss = 0;
					end else if (gap == 1)
						loss = 0;
					else if (gap < 16)
						loss = 16 * gap;
					else
						loss = 255;
				end
				succ = prior > loss ? prior - loss : 0;
				met = (prior * m_swt + rnd * m_rwt) >> 8;
				if (met > 255)
					met = 255;
				m_naddr[slot] = src;
				m_nseq[slot] = seq;
				m_nsucc[slot] = 8'(succ);
				m_nqual[slot] = 8'(met);
				r.nstat = (n < 0) ? NS_ADDED : NS_UPDATED;
				r.nslot = 5'(slot);
				r.nqual = 8'(met);
				if (n < 0)
					m_ncount++;
				offer_route(src, src, 8'd1, 8'(met), 8'(met), r);
			end
			CMD_ADVERT: begin
				n = find_neighbor(src);
				if (n < 0) begin
					r.nstat = NS_UNKNOWN;
					return r;
				end
				r.nslot = 5'(n);
				r.nqual = m_nqual[n];
				hops = (adist == 255) ? 255 : adist + 1;
				met = (m_nqual[n] + amet * (hops - 1)) / hops;
				offer_route(tgt, src, 8'(hops), amet, 8'(met), r);
			end
			CMD_LOOKUP: begin
				hit = -1;
				for (int i = 0; i < m_rcount; i++)
					if (m_rdest[i] == tgt)
						hit = i;
				if (hit < 0)
					r.rstat = RS_MISS;
				else begin
					r.rstat = RS_HIT;
					r.rslot = 6'(hit);
					r.hop = m_rhop[hit];
					r.hops = m_rdist[hit];
					r.rqual = m_rqual[hit];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic send_request(input cmd_t c, input logic [47:0] src, input logic [7:0] seq,
			input logic [7:0] rnd, input logic [47:0] tgt, input logic [7:0] adist,
			input logic [7:0] amet);
		while ($urandom_range(99) < idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.cmd <= c;
		req.source_address <= src;
		req.sequence_req <= seq;
		req.randomness <= rnd;
		req.target_address <= tgt;
		req.advertised_distance <= adist;
		req.advertised_metric <= amet;
		do
			@(posedge clk);
		while (!req.ready);
		// valid stays up until the next request or drain; ready is low meanwhile
		pending_results.push_back(predict_table(c, src, seq, rnd, tgt, adist, amet));
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [47:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do
			@(posedge clk);
		while (!cfg.ready);
		cfg.valid <= 1'b0;
		case (idx)
			REG_LOCAL_ADDR: m_local = val;
			REG_SUCC_WT: m_swt = val[7:0];
			default: m_rwt = val[7:0];
		endcase
		@(posedge clk);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (300)
			@(posedge clk);
	endtask

	// result checker
	always @(posedge clk) begin
		table_result_t w;
		cycles <= cycles + 1;
		if (rsp.valid && rsp.ready) begin
			if (pending_results.size() == 0)
				report("unexpected result", 48'd0, 48'd0);
			else begin
				w = pending_results.pop_front();
				if (rsp.neighbor_status !== w.nstat)
					report("neighbor_status", 48'(rsp.neighbor_status), 48'(w.nstat));
				if (rsp.neighbor_slot !== w.nslot)
					report("neighbor_slot", 48'(rsp.neighbor_slot), 48'(w.nslot));
				if (rsp.neighbor_quality !== w.nqual)
					report("neighbor_quality", 48'(rsp.neighbor_quality), 48'(w.nqual));
				if (rsp.route_status !== w.rstat)
					report("route_status", 48'(rsp.route_status), 48'(w.rstat));
				if (rsp.route_slot !== w.rslot)
					report("route_slot", 48'(rsp.route_slot), 48'(w.rslot));
				if (rsp.next_hop !== w.hop)
					report("next_hop", rsp.next_hop, w.hop);
				if (rsp.route_hops !== w.hops)
					report("route_hops", 48'(rsp.route_hops), 48'(w.hops));
				if (rsp.route_quality !== w.rqual)
					report("route_quality", 48'(rsp.route_quality), 48'(w.rqual));
			end
		end
		if (cycles > 3000000) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// receiver: random stalls, or a long hold-off while hold_cycles runs down
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			rsp.ready <= 1'b0;
		end else
			rsp.ready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic logic [47:0] rand_addr();
		return 48'({$urandom, $urandom});
	endfunction

	task automatic test_directed();
		// all-ones and all-zero fields, first hellos, loss steps, advert edges
		send_request(CMD_LOOKUP, 48'd0, 8'd0, 8'd0, 48'hFFFF_FFFF_FFFF, 8'd0, 8'd0);
		send_request(CMD_ADVERT, 48'h1, 8'd0, 8'd0, 48'h2, 8'd3, 8'd9);
		send_request(CMD_HELLO, 48'hFFFF_FFFF_FFFF, 8'hFF, 8'hFF, 48'd0, 8'd0, 8'd0);
		send_request(CMD_HELLO, 48'hFFFF_FFFF_FFFF, 8'h00, 8'h00, 48'd0, 8'd0, 8'd0);
		send_request(CMD_HELLO, 48'hFFFF_FFFF_FFFF, 8'h05, 8'h80, 48'd0, 8'd0, 8'd0);
		send_request(CMD_HELLO, 48'hFFFF_FFFF_FFFF, 8'h05, 8'h80, 48'd0, 8'd0, 8'd0);
		send_request(CMD_HELLO, 48'hFFFF_FFFF_FFFF, 8'h15, 8'h01, 48'd0, 8'd0, 8'd0);
		send_request(CMD_HELLO, 48'd0, 8'd7, 8'd200, 48'd0, 8'd0, 8'd0); // to self
		send_request(CMD_ADVERT, 48'hFFFF_FFFF_FFFF, 8'd0, 8'd0, 48'h55, 8'd255, 8'd255);
		send_request(CMD_ADVERT, 48'hFFFF_FFFF_FFFF, 8'd0, 8'd0, 48'h66, 8'd0, 8'd0);
		send_request(CMD_ADVERT, 48'd0, 8'd0, 8'd0, 48'h55, 8'd2, 8'd10);
		send_request(CMD_ADVERT, 48'd0, 8'd0, 8'd0, 48'h66, 8'd0, 8'd50);
		send_request(CMD_ADVERT, 48'hFFFF_FFFF_FFFF, 8'd0, 8'd0, 48'd0, 8'd1, 8'd1);
		send_request(CMD_LOOKUP, 48'd0, 8'd0, 8'd0, 48'h55, 8'd0, 8'd0);
		send_request(CMD_LOOKUP, 48'd0, 8'd0, 8'd0, 48'h77, 8'd0, 8'd0);
		send_request(CMD_NONE, 48'hFFFF_FFFF_FFFF, 8'hFF, 8'hFF, 48'hFFFF_FFFF_FFFF,
			8'hFF, 8'hFF);
		drain();
	endtask

	task automatic test_random(input int count, input int pool_n);
		cmd_t c;
		int k;
		logic [47:0] src, tgt;
		for (int i = 0; i < count; i++) begin
			k = $urandom_range(99);
			c = k < 40 ? CMD_HELLO : k < 75 ? CMD_ADVERT : k < 97 ? CMD_LOOKUP : CMD_NONE;
			src = ($urandom_range(9) == 0) ? rand_addr() : addr_pool[$urandom_range(pool_n - 1)];
			tgt = ($urandom_range(5) == 0) ? rand_addr() : addr_pool[$urandom_range(15)];
			if ($urandom_range(19) == 0)
				tgt = m_local;
			send_request(c, src, 8'($urandom_range(255)), 8'($urandom_range(255)), tgt,
				($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(6)),
				8'($urandom_range(255)));
		end
		drain();
	endtask

	task automatic test_backpressure();
		stall_pct = 0;
		idle_pct = 0;
		hold_cycles = 2000;
		test_random(20, 16);
	endtask

	initial begin
		req.valid = 1'b0;
		req.cmd = CMD_NONE;
		req.source_address = '0;
		req.sequence_req = '0;
		req.randomness = '0;
		req.target_address = '0;
		req.advertised_distance = '0;
		req.advertised_metric = '0;
		rsp.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_LOCAL_ADDR;
		cfg.data = '0;
		m_local = '0;
		m_swt = SUCC_WEIGHT_RST;
		m_rwt = RAND_WEIGHT_RST;
		m_ncount = 0;
		m_rcount = 0;
		for (int i = 0; i < 16; i++)
			addr_pool[i] = rand_addr();
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(250, 16);
		write_register(REG_SUCC_WT, 48'd255);
		write_register(REG_RAND_WT, 48'd255);
		write_register(REG_LOCAL_ADDR, addr_pool[3]);
		idle_pct = 79;
		test_random(250, 16);
		write_register(REG_SUCC_WT, 48'd0);
		write_register(REG_RAND_WT, 48'd0);
		write_register(REG_LOCAL_ADDR, 48'hFFFF_FFFF_FFFF);
		idle_pct = 0;
		stall_pct = 79;
		test_random(250, 16);
		write_register(REG_SUCC_WT, 48'd128);
		write_register(REG_RAND_WT, 48'd77);
		idle_pct = 25;
		stall_pct = 25;
		// wide address spread fills the neighbor table
		for (int i = 0; i < 16; i++)
			addr_pool[i] = rand_addr();
		test_random(200, 16);
		test_backpressure();
		idle_pct = 0;
		stall_pct = 0;
		for (int i = 0; i < 40; i++)
			send_request(CMD_HELLO, rand_addr(), 8'($urandom_range(255)),
				8'($urandom_range(255)), 48'd0, 8'd0, 8'd0);
		test_random(230, 16);

		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: files.f
sv/mnrt_pkg.sv
sv/mnrt_if.sv
sv/mnrt_divider.sv
sv/mnrt_nbr_mem.sv
sv/mnrt_rt_mem.sv
sv/mesh_neighbor_route_table.sv
bench/mesh_neighbor_route_table_tb.sv
